FILE: hdl/lppd_pkg.sv
// Shared package for the length-prefixed packet deframer.
// Holds header constants, the per-byte result record and the queue depth.
// No dependencies.
`timescale 1ns / 1ps

package lppd_pkg;

  // Header layout: 4-byte channel word, then 4-byte total length
  localparam int unsigned HEADER_BYTES      = 8;
  localparam int unsigned CHANNEL_BYTES     = 4;
  localparam int unsigned POSITION_BITS_DEF = 24;
  localparam int unsigned MAX_BITS          = 24;
  localparam logic [MAX_BITS-1:0] MAX_RESET = 24'h200000;

  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // One result item as it travels from front to back
  typedef struct packed {
    logic [31:0] packet_channel;
    logic        length_error;
    logic        last_byte;
    logic        first_byte;
    logic [23:0] byte_position;
    logic [7:0]  out_byte;
  } result_t;

endpackage

FILE: hdl/length_prefixed_packet_deframer.sv
// Channel | Dir | Signals                          | Contents
// in      | in  | in_tvalid/in_tready/in_tdata     | one raw stream byte
// out     | out | out_tvalid/out_tready/out_tdata  | byte, position, channel
//         |     | out_tuser/out_tlast              | flags, end of packet
// cfg     | in  | cfg_valid/cfg_ready/cfg_data     | max packet length
//
// One byte per cycle sustained while out_tready is high; after an input
// accept, the result is written into the queue and then moved into the
// output register, which drives out_tvalid.
// The front stalls only when the two-entry queue is full; the output
// register refills in the same cycle its item is taken if the queue holds one.
// Synchronous active-low reset clears the header state, queue and output
// valid, and loads the max length with 2 MiB. cfg writes are always taken.
// Top level of the length-prefixed packet deframer; uses lppd_pkg,
// lppd_front, lppd_queue and lppd_back.
`timescale 1ns / 1ps

module length_prefixed_packet_deframer #(
  parameter int unsigned POSITION_BITS = lppd_pkg::POSITION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // stream input
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] data_byte
  // stream output
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [63:0]                   out_tdata,  // [7:0] out_byte,
                                                    // [31:8] byte_position,
                                                    // [63:32] packet_channel
  output logic [1:0]                    out_tuser,  // [0] first_byte,
                                                    // [1] length_error
  output logic                          out_tlast,  // last_byte
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lppd_pkg::MAX_BITS-1:0] cfg_data    // [23:0] max_packet_bytes
);

  lppd_pkg::result_t front_res;
  lppd_pkg::result_t q_data;
  logic              q_full, q_valid, q_pop, in_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  lppd_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_byte   (in_tdata),
    .res       (front_res)
  );

  lppd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (front_res),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  lppd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: hdl/lppd_front.sv
// Front stage of the deframer: holds the max-length register and the
// per-packet header state, classifies each byte and builds its result.
// Depends on lppd_pkg.
`timescale 1ns / 1ps

module lppd_front #(
  parameter int unsigned POSITION_BITS = lppd_pkg::POSITION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [lppd_pkg::MAX_BITS-1:0]    cfg_data,
  input  logic                             in_fire,
  input  logic [7:0]                       in_byte,
  output lppd_pkg::result_t                res
);

  // Largest length a position counter of this width can reach
  localparam logic [32:0] CAP = 33'd1 << POSITION_BITS;
  localparam logic [32:0] HDR = 33'(lppd_pkg::HEADER_BYTES);
  localparam logic [32:0] CHN = 33'(lppd_pkg::CHANNEL_BYTES);

  logic [lppd_pkg::MAX_BITS-1:0] max_r;
  logic [POSITION_BITS-1:0]      pos_r, pos_nxt;
  logic [31:0]                   chan_r, chan_nxt;
  logic [31:0]                   len_r, len_nxt;
  logic                          err_r, err_nxt;

  logic [32:0] pos_w;
  logic [31:0] pos32;
  logic [31:0] len_shift;
  logic [32:0] eff_max;
  logic        pos_zero, pos_hdr_last, len_short, len_long, last;
  logic [31:0] len_fin;

  // Max-length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= lppd_pkg::MAX_RESET;
    end else if (cfg_valid) begin
      max_r <= cfg_data;
    end
  end

  // Effective maximum: at least a header, at most the counter range
  always_comb begin
    eff_max = {9'd0, max_r};
    if (eff_max < HDR) begin
      eff_max = HDR;
    end
    if (eff_max > CAP) begin
      eff_max = CAP;
    end
  end

  // Position decode and header shift
  assign pos_w        = 33'(pos_r);
  assign pos32        = 32'(pos_r);
  assign pos_zero     = (pos_w == 33'd0);
  assign pos_hdr_last = (pos_w == HDR - 33'd1);
  assign len_shift    = {len_r[23:0], in_byte};
  assign len_short    = ({1'b0, len_shift} < HDR);
  assign len_long     = ({1'b0, len_shift} > eff_max);

  always_comb begin
    if (len_short) begin
      len_fin = HDR[31:0];
    end else if (len_long) begin
      len_fin = eff_max[31:0];
    end else begin
      len_fin = len_shift;
    end
  end

  // Next header state and end-of-packet decision
  always_comb begin
    chan_nxt = chan_r;
    len_nxt  = len_r;
    err_nxt  = err_r;
    last     = 1'b0;
    if (pos_zero) begin
      chan_nxt = {24'd0, in_byte};
      len_nxt  = 32'd0;
      err_nxt  = 1'b0;
    end else if (pos_w < CHN) begin
      chan_nxt = {chan_r[23:0], in_byte};
    end else if (pos_w < HDR) begin
      len_nxt = len_shift;
    end

    if (pos_hdr_last) begin
      len_nxt = len_fin;
      err_nxt = len_short | len_long;
      last    = ({1'b0, len_fin} == HDR);
    end else if (pos_w >= HDR) begin
      last = ((pos_w + 33'd1) >= {1'b0, len_r});
    end

    pos_nxt = last ? '0 : pos_r + 1'b1;
  end

  // Result for the byte being accepted
  always_comb begin
    res.out_byte       = in_byte;
    res.byte_position  = pos32[23:0];
    res.first_byte     = pos_zero;
    res.last_byte      = last;
    res.packet_channel = (pos_w >= CHN) ? chan_nxt : 32'd0;
    res.length_error   = (pos_w >= HDR - 33'd1) && err_nxt;
  end

  // Packet state advances on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      chan_r <= '0;
      len_r  <= '0;
      err_r  <= 1'b0;
    end else if (in_fire) begin
      pos_r  <= pos_nxt;
      chan_r <= chan_nxt;
      len_r  <= len_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

FILE: hdl/lppd_queue.sv
// Short result queue between front and back of the deframer.
// Two-entry FIFO of lppd_pkg::result_t records.
// Depends on lppd_pkg.
`timescale 1ns / 1ps

module lppd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lppd_pkg::result_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output lppd_pkg::result_t q_data
);

  localparam int unsigned PTR_BITS = $clog2(lppd_pkg::QUEUE_DEPTH);

  lppd_pkg::result_t   mem [lppd_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_BITS:0]   count_r, count_nxt;

  assign full    = (count_r == (PTR_BITS+1)'(lppd_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = mem[rd_ptr_r];

  // Occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hdl/lppd_back.sv
// Back stage of the deframer: output register that presents result items
// on the stream master side and pulls from the queue. Depends on lppd_pkg.
`timescale 1ns / 1ps

module lppd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  lppd_pkg::result_t q_data,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  logic              valid_r;
  lppd_pkg::result_t res_r;

  // Refill when empty or when the held item leaves this cycle
  assign pop = q_valid && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= q_data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.packet_channel, res_r.byte_position, res_r.out_byte};
  assign out_tuser  = {res_r.length_error, res_r.first_byte};
  assign out_tlast  = res_r.last_byte;

endmodule

FILE: hdl/lppd_checker.sv
// Port-level checker for the deframer output stream, with its bind.
// Depends on the ports of length_prefixed_packet_deframer only.
`timescale 1ns / 1ps

module lppd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // Stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item changed while stalled");

  // First-byte flag exactly at position zero
  a_first_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == (out_tdata[31:8] == 24'd0)))
    else $error("first-byte flag disagrees with position");

  // Channel is not shown before the channel word is complete
  a_chan_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[31:8] < 24'd4) |-> (out_tdata[63:32] == 32'd0))
    else $error("channel shown inside channel header bytes");

  // Length error cannot show before the last header byte
  a_err_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[31:8] < 24'd7) |-> !out_tuser[1])
    else $error("length error shown before length is known");

endmodule

bind length_prefixed_packet_deframer lppd_checker u_lppd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
